// ----- hw/rtl/trial_division_prime_test_defines.svh -----
// Assertion macros for the checker file of the prime tester.
// No dependencies; included by bare file name.
`ifndef TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define TDP_ASSERT_NOW(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define TDP_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- hw/rtl/tdp_pkg.sv -----
// Shared constants, types and width helpers for the trial-division prime tester.
// No dependencies.
`timescale 1ns / 1ps

package tdp_pkg;

   // Working width of the number under test (4 .. 64).
   localparam int WIDTH = 32;
   // Port width of the number, factor and cofactor fields.
   localparam int FIELD_W = 32;
   // Bit counter of the serial divider: must hold WIDTH itself.
   localparam int CNT_W = $clog2(WIDTH + 1);

   localparam logic [WIDTH-1:0] D_FIRST = WIDTH'(3);
   localparam logic [WIDTH-1:0] D_STEP = WIDTH'(2);
   localparam logic [WIDTH-1:0] F_TWO = WIDTH'(2);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_CHECK,
      ST_FINISH
   } state_type;

   // Port field -> working width (zero-extend or truncate).
   function automatic logic [WIDTH-1:0] to_work(input logic [FIELD_W-1:0] v);
      logic [63:0] t;
      t = 64'(v);
      return t[WIDTH-1:0];
   endfunction

   // Working width -> port field (zero-extend or truncate).
   function automatic logic [FIELD_W-1:0] to_field(input logic [WIDTH-1:0] v);
      logic [63:0] t;
      t = 64'(v);
      return t[FIELD_W-1:0];
   endfunction

endpackage

// ----- hw/rtl/tdp_divider.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on tdp_pkg.
`timescale 1ns / 1ps

module tdp_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [tdp_pkg::WIDTH-1:0] dividend,
   input  logic [tdp_pkg::WIDTH-1:0] divisor,
   output logic                      done,
   output logic [tdp_pkg::WIDTH-1:0] quotient,
   output logic [tdp_pkg::WIDTH-1:0] remainder
);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [tdp_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [tdp_pkg::WIDTH-1:0] rem_ff, rem_in;
   logic [tdp_pkg::WIDTH-1:0] quo_ff, quo_in;
   logic [tdp_pkg::WIDTH-1:0] div_ff, div_in;

   logic [tdp_pkg::WIDTH:0]   trial;
   logic [tdp_pkg::WIDTH:0]   diff;
   logic                      fits;

   // Shift the next dividend bit into the partial remainder, subtract if it fits.
   always_comb begin
      trial = {rem_ff, quo_ff[tdp_pkg::WIDTH-1]};
      diff  = trial - {1'b0, div_ff};
      fits  = (trial >= {1'b0, div_ff});
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = tdp_pkg::CNT_W'(tdp_pkg::WIDTH);
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[tdp_pkg::WIDTH-1:0] : trial[tdp_pkg::WIDTH-1:0];
         quo_in = {quo_ff[tdp_pkg::WIDTH-2:0], fits};
         cnt_in = cnt_ff - tdp_pkg::CNT_W'(1);
         if (cnt_ff == tdp_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ----- hw/rtl/trial_division_prime_test.sv -----
// Top level of the trial-division prime tester: control FSM, result register.
// Depends on tdp_pkg and tdp_divider.
`timescale 1ns / 1ps

//  channel | direction | handshake         | beat payload
//  req     | in        | req_valid/stall   | number (32b unsigned)
//  rsp     | out       | rsp_valid/stall   | is_prime, factor, cofactor (1b/32b/32b)
//
//  Paths: numbers below 4 and even numbers go from IDLE straight to FINISH, with no divider pass.
//  An odd number runs trials with divisors 3,5,7,... until one divides it or passes sqrt(n);
//  each trial is one pass of the bit-serial divider followed by the CHECK state.
//  Worst case, a 32-bit prime: about 32768 trials.
//  Reset: synchronous, active high; clears FSM, divider control and rsp_valid.
//  Stalls: one beat is worked on at a time; a finished result sits in the rsp register
//  while the next number is accepted, and req_stall is high whenever work is in flight.

module trial_division_prime_test (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [tdp_pkg::FIELD_W-1:0] req_number,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_is_prime,
   output logic [tdp_pkg::FIELD_W-1:0] rsp_factor,
   output logic [tdp_pkg::FIELD_W-1:0] rsp_cofactor
);

   tdp_pkg::state_type state_ff, state_in;

   // Working registers for the number in flight.
   logic [tdp_pkg::WIDTH-1:0] num_ff, num_in;
   logic [tdp_pkg::WIDTH-1:0] d_ff, d_in;          // current trial divisor
   logic                      res_prime_ff, res_prime_in;
   logic [tdp_pkg::WIDTH-1:0] res_fac_ff, res_fac_in;
   logic [tdp_pkg::WIDTH-1:0] res_cof_ff, res_cof_in;

   // Output register.
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_prime_ff, rsp_prime_in;
   logic [tdp_pkg::FIELD_W-1:0] rsp_fac_ff, rsp_fac_in;
   logic [tdp_pkg::FIELD_W-1:0] rsp_cof_ff, rsp_cof_in;

   logic                      req_accept;
   logic [tdp_pkg::WIDTH-1:0] req_work;
   logic                      below_two, below_four, is_even, trivial;
   logic                      out_free, out_load;
   logic                      div_start, div_done;
   logic [tdp_pkg::WIDTH-1:0] div_dividend, div_quo, div_rem;
   logic                      past_root, exact, stop;

   // Classification of the incoming number (only meaningful in IDLE).
   always_comb begin
      req_work   = tdp_pkg::to_work(req_number);
      below_two  = (req_work[tdp_pkg::WIDTH-1:1] == '0);
      below_four = (req_work[tdp_pkg::WIDTH-1:2] == '0);
      is_even    = ~req_work[0];
      trivial    = below_four | is_even;
   end

   // Trial outcome: d > n/d means no divisor up to sqrt(n) is left, so n is prime.
   always_comb begin
      past_root = (d_ff > div_quo);
      exact     = (div_rem == '0);
      stop      = past_root | exact;
   end

   assign req_accept = req_valid & ~req_stall;
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tdp_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = trivial ? tdp_pkg::ST_FINISH : tdp_pkg::ST_DIV;
            end
         end
         tdp_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = tdp_pkg::ST_CHECK;
            end
         end
         tdp_pkg::ST_CHECK: begin
            state_in = stop ? tdp_pkg::ST_FINISH : tdp_pkg::ST_DIV;
         end
         tdp_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = tdp_pkg::ST_IDLE;
            end
         end
         default: state_in = tdp_pkg::ST_IDLE;
      endcase
   end

   // FSM outputs.
   always_comb begin
      req_stall = 1'b1;
      div_start = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         tdp_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            div_start = req_valid & ~trivial;
         end
         tdp_pkg::ST_DIV: begin
         end
         tdp_pkg::ST_CHECK: begin
            div_start = ~stop;
         end
         tdp_pkg::ST_FINISH: begin
            out_load = out_free;
         end
         default: begin
         end
      endcase
   end

   // Datapath.
   always_comb begin
      num_in       = num_ff;
      d_in         = d_ff;
      res_prime_in = res_prime_ff;
      res_fac_in   = res_fac_ff;
      res_cof_in   = res_cof_ff;
      if (req_accept) begin
         num_in       = req_work;
         d_in         = tdp_pkg::D_FIRST;
         res_prime_in = 1'b0;
         res_fac_in   = '0;
         res_cof_in   = '0;
         priority if (below_two) begin
            res_prime_in = 1'b0;
         end else if (below_four) begin
            res_prime_in = 1'b1;   // 2 and 3
         end else if (is_even) begin
            res_fac_in = tdp_pkg::F_TWO;
            res_cof_in = req_work >> 1;
         end else begin
            // odd, 5 and up: the divider search decides
         end
      end else if (state_ff == tdp_pkg::ST_CHECK) begin
         priority if (past_root) begin
            res_prime_in = 1'b1;
         end else if (exact) begin
            res_fac_in = d_ff;
            res_cof_in = div_quo;
         end else begin
            d_in = d_ff + tdp_pkg::D_STEP;
         end
      end
   end

   assign div_dividend = (state_ff == tdp_pkg::ST_IDLE) ? req_work : num_ff;

   tdp_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (d_in),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Result register: loaded from FINISH, cleared when the beat is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_prime_in = rsp_prime_ff;
      rsp_fac_in   = rsp_fac_ff;
      rsp_cof_in   = rsp_cof_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_prime_in = res_prime_ff;
         rsp_fac_in   = tdp_pkg::to_field(res_fac_ff);
         rsp_cof_in   = tdp_pkg::to_field(res_cof_ff);
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tdp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      num_ff       <= num_in;
      d_ff         <= d_in;
      res_prime_ff <= res_prime_in;
      res_fac_ff   <= res_fac_in;
      res_cof_ff   <= res_cof_in;
      rsp_prime_ff <= rsp_prime_in;
      rsp_fac_ff   <= rsp_fac_in;
      rsp_cof_ff   <= rsp_cof_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = rsp_prime_ff;
   assign rsp_factor   = rsp_fac_ff;
   assign rsp_cofactor = rsp_cof_ff;

endmodule

// ----- hw/rtl/tdp_checker.sv -----
// Port-level checker for the prime tester, bound to the top level.
// Depends on trial_division_prime_test_defines.svh and tdp_pkg.
`timescale 1ns / 1ps
`include "trial_division_prime_test_defines.svh"

module tdp_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic [tdp_pkg::FIELD_W-1:0] req_number,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic                        rsp_is_prime,
   input logic [tdp_pkg::FIELD_W-1:0] rsp_factor,
   input logic [tdp_pkg::FIELD_W-1:0] rsp_cofactor
);

   logic req_beat;
   logic [tdp_pkg::FIELD_W-1:0] req_seen;

   assign req_beat = req_valid & ~req_stall;
   assign req_seen = req_number;

   // A prime carries no factor pair.
   `TDP_ASSERT_NOW(a_prime_no_factor, rsp_valid && rsp_is_prime, rsp_factor == '0 && rsp_cofactor == '0, "prime result with nonzero factor")

   // A reported factor belongs to a non-prime result, is at least 2 and is not above its cofactor.
   `TDP_ASSERT_NOW(a_factor_smallest, rsp_valid && rsp_factor != '0, !rsp_is_prime && rsp_factor >= 2 && rsp_factor <= rsp_cofactor && req_seen == req_number, "factor out of order")

   // One number at a time: after a beat is taken the request side is held off.
   `TDP_ASSERT_NEXT(a_busy_after_accept, req_beat, req_stall, "request accepted while busy")

   // A stalled result stays put.
   `TDP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_is_prime) && $stable(rsp_factor) && $stable(rsp_cofactor), "stalled result changed")

endmodule

bind trial_division_prime_test tdp_checker u_tdp_checker (.*);
